### src/upd_pkg.sv
package upd_pkg;

  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_ESC  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  // One queued command: a name byte to store, or the end of a URL.
  typedef struct packed {
    logic       is_end;
    logic       esc_err;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_R1,
    BK_R2,
    BK_R3,
    BK_SCAN,
    BK_WRITE,
    BK_EMIT_START,
    BK_EMIT,
    BK_TERM
  } bk_state_t;

endpackage

### src/upd_ram.sv
module upd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/upd_front.sv
module upd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    url_byte,
  input  logic          end_of_url,
  output logic          push,
  output upd_pkg::cmd_t cmd
);

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_HI   = 2'd1;
  localparam logic [1:0] ESC_LO   = 2'd2;

  // 0..15 for a hexit, 16 otherwise
  function automatic logic [4:0] hexit_value(input logic [7:0] b);
    logic [7:0] v;
    logic [7:0] w;
    v = b - 8'd48;
    w = (v | 8'd32) - 8'd49;
    if (v < 8'd10) begin
      hexit_value = v[4:0];
    end else if (w < 8'd6) begin
      hexit_value = w[4:0] + 5'd10;
    end else begin
      hexit_value = 5'd16;
    end
  endfunction

  logic [1:0] escape_phase, escape_phase_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic       query_seen, query_seen_next;
  logic       esc_err, esc_err_next;
  logic [4:0] hex;
  logic       url_end;
  logic       in_esc;

  assign hex     = hexit_value(url_byte);
  assign url_end = end_of_url || (url_byte == 8'h00);
  assign in_esc  = (escape_phase == ESC_HI) || (escape_phase == ESC_LO);

  always_comb begin
    escape_phase_next = escape_phase;
    high_nibble_next  = high_nibble;
    query_seen_next   = query_seen;
    esc_err_next      = esc_err;
    push              = 1'b0;
    cmd.is_end        = 1'b0;
    cmd.esc_err       = 1'b0;
    cmd.data          = url_byte;
    if (accept) begin
      if (url_end) begin
        push              = 1'b1;
        cmd.is_end        = 1'b1;
        cmd.esc_err       = esc_err || in_esc;
        cmd.data          = 8'h00;
        escape_phase_next = ESC_NONE;
        high_nibble_next  = 4'd0;
        query_seen_next   = 1'b0;
        esc_err_next      = 1'b0;
      end else if (!esc_err && !query_seen) begin
        if (in_esc) begin
          if (hex[4]) begin
            esc_err_next      = 1'b1;
            escape_phase_next = ESC_NONE;
          end else if (escape_phase == ESC_HI) begin
            high_nibble_next  = hex[3:0];
            escape_phase_next = ESC_LO;
          end else begin
            escape_phase_next = ESC_NONE;
            push              = 1'b1;
            cmd.data          = {high_nibble, hex[3:0]};
          end
        end else if (url_byte == upd_pkg::CH_QUERY) begin
          query_seen_next = 1'b1;
        end else if (url_byte == upd_pkg::CH_PCT) begin
          escape_phase_next = ESC_HI;
        end else begin
          push     = 1'b1;
          cmd.data = (url_byte == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : url_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_phase <= ESC_NONE;
      high_nibble  <= 4'd0;
      query_seen   <= 1'b0;
      esc_err      <= 1'b0;
    end else begin
      escape_phase <= escape_phase_next;
      high_nibble  <= high_nibble_next;
      query_seen   <= query_seen_next;
      esc_err      <= esc_err_next;
    end
  end

endmodule

### src/upd_queue.sv
module upd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  upd_pkg::cmd_t push_cmd,
  input  logic          pop,
  output upd_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);

  upd_pkg::cmd_t entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign head  = entry[rd_ptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### src/upd_back.sv
module upd_back #(
  parameter int MAX_NAME = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  upd_pkg::cmd_t head,
  output logic          pop,
  output logic          name_valid,
  output logic [7:0]    name_byte,
  output logic          last,
  output logic [1:0]    status
);

  localparam int IDX_W = $clog2(MAX_NAME + 1);
  localparam int AW    = $clog2(MAX_NAME);

  upd_pkg::bk_state_t state, state_next, fin_state;
  logic [IDX_W-1:0]   wi, wi_next;
  logic               err2, err2_next;
  upd_pkg::cmd_t      cur, cur_next;
  logic [AW-1:0]      idx, idx_next;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [7:0]         wdata;
  logic [AW-1:0]      raddr;
  logic [7:0]         rdata;

  upd_ram #(
    .WIDTH(8),
    .DEPTH(MAX_NAME)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // where a finished trim goes: store the pending byte, or dump the name
  assign fin_state = cur.is_end ? upd_pkg::BK_EMIT_START : upd_pkg::BK_WRITE;

  always_comb begin
    state_next = state;
    case (state)
      upd_pkg::BK_IDLE: begin
        if (!empty) begin
          if (head.is_end) begin
            if (err2 || head.esc_err) begin
              state_next = upd_pkg::BK_TERM;
            end else if (wi != '0) begin
              state_next = upd_pkg::BK_R1;
            end else begin
              state_next = upd_pkg::BK_EMIT_START;
            end
          end else if (!err2 && head.data == upd_pkg::CH_SLASH && wi != '0) begin
            state_next = upd_pkg::BK_R1;
          end
        end
      end
      upd_pkg::BK_R1: begin
        if (rdata == upd_pkg::CH_SLASH || rdata != upd_pkg::CH_DOT
            || wi <= IDX_W'(1)) begin
          state_next = fin_state;
        end else begin
          state_next = upd_pkg::BK_R2;
        end
      end
      upd_pkg::BK_R2: begin
        if (rdata == upd_pkg::CH_DOT && wi > IDX_W'(2)) begin
          state_next = upd_pkg::BK_R3;
        end else begin
          state_next = fin_state;
        end
      end
      upd_pkg::BK_R3: begin
        if (rdata == upd_pkg::CH_SLASH && wi != IDX_W'(3)) begin
          state_next = upd_pkg::BK_SCAN;
        end else begin
          state_next = fin_state;
        end
      end
      upd_pkg::BK_SCAN: begin
        if (rdata == upd_pkg::CH_SLASH || wi == '0) begin
          state_next = fin_state;
        end
      end
      upd_pkg::BK_WRITE: begin
        state_next = upd_pkg::BK_IDLE;
      end
      upd_pkg::BK_EMIT_START: begin
        state_next = (wi == '0) ? upd_pkg::BK_TERM : upd_pkg::BK_EMIT;
      end
      upd_pkg::BK_EMIT: begin
        if (IDX_W'(idx) + IDX_W'(1) == wi) begin
          state_next = upd_pkg::BK_TERM;
        end
      end
      upd_pkg::BK_TERM: begin
        state_next = upd_pkg::BK_IDLE;
      end
      default: begin
        state_next = upd_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    wi_next   = wi;
    err2_next = err2;
    cur_next  = cur;
    idx_next  = idx;
    pop       = 1'b0;
    we        = 1'b0;
    waddr     = AW'(wi);
    wdata     = cur.data;
    raddr     = AW'(wi - IDX_W'(1));
    case (state)
      upd_pkg::BK_IDLE: begin
        if (!empty) begin
          pop      = 1'b1;
          cur_next = head;
          // plain bytes go straight in; a slash needs a look back first
          if (!head.is_end && !err2
              && !(head.data == upd_pkg::CH_SLASH && wi != '0)) begin
            we      = 1'b1;
            wdata   = head.data;
            wi_next = wi + IDX_W'(1);
            if (wi >= IDX_W'(MAX_NAME - 1)) begin
              err2_next = 1'b1;
            end
          end
        end
      end
      upd_pkg::BK_R1: begin
        if (rdata == upd_pkg::CH_SLASH) begin
          if (!cur.is_end) begin
            wi_next = wi - IDX_W'(1);
          end
        end else if (rdata == upd_pkg::CH_DOT) begin
          if (wi <= IDX_W'(1)) begin
            wi_next = '0;
          end else begin
            raddr = AW'(wi - IDX_W'(2));
          end
        end
      end
      upd_pkg::BK_R2: begin
        if (rdata == upd_pkg::CH_SLASH) begin
          wi_next = wi - IDX_W'(2);
        end else if (rdata == upd_pkg::CH_DOT) begin
          if (wi <= IDX_W'(2)) begin
            wi_next = '0;
          end else begin
            raddr = AW'(wi - IDX_W'(3));
          end
        end
      end
      upd_pkg::BK_R3: begin
        // "/.." : drop it, then walk back to the previous slash
        if (rdata == upd_pkg::CH_SLASH) begin
          if (wi == IDX_W'(3)) begin
            wi_next = '0;
          end else begin
            wi_next = wi - IDX_W'(4);
            raddr   = AW'(wi - IDX_W'(4));
          end
        end
      end
      upd_pkg::BK_SCAN: begin
        if (rdata != upd_pkg::CH_SLASH && wi != '0) begin
          wi_next = wi - IDX_W'(1);
          raddr   = AW'(wi - IDX_W'(1));
        end
      end
      upd_pkg::BK_WRITE: begin
        we      = 1'b1;
        wi_next = wi + IDX_W'(1);
        if (wi >= IDX_W'(MAX_NAME - 1)) begin
          err2_next = 1'b1;
        end
      end
      upd_pkg::BK_EMIT_START: begin
        raddr    = '0;
        idx_next = '0;
      end
      upd_pkg::BK_EMIT: begin
        raddr    = idx + AW'(1);
        idx_next = idx + AW'(1);
      end
      upd_pkg::BK_TERM: begin
        wi_next   = '0;
        err2_next = 1'b0;
      end
      default: begin
        wi_next = wi;
      end
    endcase
  end

  always_comb begin
    name_valid = (state == upd_pkg::BK_EMIT) || (state == upd_pkg::BK_TERM);
    name_byte  = (state == upd_pkg::BK_EMIT) ? rdata : 8'h00;
    last       = (state == upd_pkg::BK_TERM);
    status     = upd_pkg::ST_OK;
    if (state == upd_pkg::BK_TERM) begin
      if (err2) begin
        status = upd_pkg::ST_TOO_LONG;
      end else if (cur.esc_err) begin
        status = upd_pkg::ST_BAD_ESC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= upd_pkg::BK_IDLE;
      wi    <= '0;
      err2  <= 1'b0;
    end else begin
      state <= state_next;
      wi    <= wi_next;
      err2  <= err2_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    idx <= idx_next;
  end

endmodule

### src/url_path_decoder_core.sv
// Timing: a plain name byte is stored in the cycle after it is taken when the back end is idle;
//   a slash first reads back in states R1, R2 and R3 as far as it needs and, when it closes
//   a "/.." one, walks back in SCAN to the previous slash before it is written in WRITE.
// Throughput: a word is taken each cycle while the two-entry command queue has room;
//   the back end retires one plain byte per cycle while no slash or end is in hand. An end
//   of URL gives its name bytes at one per cycle, then the terminator, once a trailing dot
//   component is dropped; after an error the terminator alone comes, straight from idle.
// Reset: synchronous; control state clears, the name store is not cleared. Results are
//   strobed for one cycle each and the receiver cannot stall them.
module url_path_decoder_core #(
  parameter int MAX_NAME = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] url_byte,
  input  logic       end_of_url,
  output logic       name_valid,
  output logic [7:0] name_byte,
  output logic       last,
  output logic [1:0] status
);

  logic          accept;
  logic          push;
  upd_pkg::cmd_t push_cmd;
  upd_pkg::cmd_t head;
  logic          pop;
  logic          empty;
  logic          full;

  assign busy   = full;
  assign accept = start && !busy;

  upd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .url_byte  (url_byte),
    .end_of_url(end_of_url),
    .push      (push),
    .cmd       (push_cmd)
  );

  upd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .empty   (empty),
    .full    (full)
  );

  upd_back #(
    .MAX_NAME(MAX_NAME)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .name_valid(name_valid),
    .name_byte (name_byte),
    .last      (last),
    .status    (status)
  );

endmodule

### src/upd_checker.sv
module upd_checker (
  input logic       clk,
  input logic       rst,
  input logic       name_valid,
  input logic [7:0] name_byte,
  input logic       last,
  input logic [1:0] status
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !name_valid)
    else $error("result strobe right after reset");

  a_last_strobed: assert property (@(posedge clk) disable iff (rst)
    last |-> name_valid)
    else $error("last without strobe");

  a_name_status: assert property (@(posedge clk) disable iff (rst)
    name_valid && !last |-> status == upd_pkg::ST_OK)
    else $error("status set on a name byte word");

  a_term_byte: assert property (@(posedge clk) disable iff (rst)
    name_valid && last |-> name_byte == 8'h00)
    else $error("terminator carries a name byte");

  a_term_gap: assert property (@(posedge clk) disable iff (rst)
    name_valid && last |=> !name_valid)
    else $error("word straight after terminator");

endmodule

bind url_path_decoder_core upd_checker u_upd_checker (
  .clk       (clk),
  .rst       (rst),
  .name_valid(name_valid),
  .name_byte (name_byte),
  .last      (last),
  .status    (status)
);

### test/url_path_decoder_core_test.sv
module url_path_decoder_core_test;

  localparam int NAME_MAX     = 64;
  localparam int RANDOM_ITEMS = 410;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int DIR_ROWS     = 9;
  localparam int REPORT_MAX   = 10;

  typedef enum logic [1:0] {ESC_NONE, ESC_HI, ESC_LO} esc_phase_t;

  typedef struct packed {
    logic [7:0] nb;
    logic       lst;
    logic [1:0] st;
  } name_word_t;

  typedef struct {
    string      url;
    logic       flag_end;
    logic       typed;
    string      name;
    logic [1:0] st;
  } url_case_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [7:0] url_byte = 8'h00;
  logic       end_of_url = 1'b0;
  logic       name_valid;
  logic [7:0] name_byte;
  logic       last;
  logic [1:0] status;

  url_path_decoder_core #(.MAX_NAME(NAME_MAX)) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .url_byte   (url_byte),
    .end_of_url (end_of_url),
    .name_valid (name_valid),
    .name_byte  (name_byte),
    .last       (last),
    .status     (status)
  );

  always #5 clk = ~clk;

  // Decoder shadow state
  logic [7:0]  name_mem [64];
  int unsigned wr_idx = 0;
  esc_phase_t  esc_ph = ESC_NONE;
  logic [3:0]  hi_nib = 4'h0;
  logic        in_query = 1'b0;
  logic [1:0]  err_code = upd_pkg::ST_OK;

  name_word_t  name_exp_q [$];
  int          case_tag_q [$];
  logic [7:0]  url_q [$];
  url_case_t   dir_rows [DIR_ROWS];

  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned items_sent = 0;

  function automatic int unsigned hexit_of(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return b - 8'h30;
    if (b >= 8'h41 && b <= 8'h46) return b - 8'h41 + 10;
    if (b >= 8'h61 && b <= 8'h66) return b - 8'h61 + 10;
    return 16;
  endfunction

  // Drop a trailing "." or ".." component; returns the new length.
  function automatic int unsigned trim_tail(input int unsigned n);
    int unsigned k;
    k = n;
    if (k == 0 || name_mem[(k - 1) % 64] != upd_pkg::CH_DOT) return k;
    if (k <= 1) return 0;
    if (name_mem[(k - 2) % 64] == upd_pkg::CH_SLASH) return k - 2;
    if (name_mem[(k - 2) % 64] == upd_pkg::CH_DOT) begin
      if (k <= 2) return 0;
      if (name_mem[(k - 3) % 64] == upd_pkg::CH_SLASH) begin
        k = k - 3;
        while (k > 0) begin
          k--;
          if (name_mem[k % 64] == upd_pkg::CH_SLASH) break;
        end
      end
    end
    return k;
  endfunction

  task automatic expect_word(input logic [7:0] nb, input logic lst, input logic [1:0] st);
    name_word_t w;
    w.nb = nb;
    w.lst = lst;
    w.st = st;
    name_exp_q.push_back(w);
  endtask

  task automatic store_byte(input logic [7:0] c);
    if (c == upd_pkg::CH_SLASH && wr_idx > 0) begin
      if (name_mem[(wr_idx - 1) % 64] == upd_pkg::CH_SLASH) wr_idx--;
      else wr_idx = trim_tail(wr_idx);
    end
    name_mem[wr_idx % 64] = c;
    wr_idx++;
    if (wr_idx >= NAME_MAX) err_code = upd_pkg::ST_TOO_LONG;
  endtask

  task automatic decode_word(input logic [7:0] b, input logic e);
    int unsigned h;
    int unsigned i;
    if (!(e || b == 8'h00)) begin
      if (err_code == upd_pkg::ST_OK && !in_query) begin
        if (esc_ph == ESC_HI || esc_ph == ESC_LO) begin
          h = hexit_of(b);
          if (h > 15) begin
            err_code = upd_pkg::ST_BAD_ESC;
            esc_ph = ESC_NONE;
          end else if (esc_ph == ESC_HI) begin
            hi_nib = h[3:0];
            esc_ph = ESC_LO;
          end else begin
            esc_ph = ESC_NONE;
            store_byte({hi_nib, h[3:0]});
          end
        end else if (b == upd_pkg::CH_QUERY) begin
          in_query = 1'b1;
        end else if (b == upd_pkg::CH_PCT) begin
          esc_ph = ESC_HI;
        end else begin
          store_byte(b == upd_pkg::CH_PLUS ? upd_pkg::CH_SPACE : b);
        end
      end
    end else begin
      if (err_code == upd_pkg::ST_OK && (esc_ph == ESC_HI || esc_ph == ESC_LO))
        err_code = upd_pkg::ST_BAD_ESC;
      if (err_code == upd_pkg::ST_OK) begin
        if (wr_idx > 0 && name_mem[(wr_idx - 1) % 64] != upd_pkg::CH_SLASH)
          wr_idx = trim_tail(wr_idx);
        for (i = 0; i < wr_idx && i < NAME_MAX - 1; i++)
          expect_word(name_mem[i % 64], 1'b0, upd_pkg::ST_OK);
      end
      expect_word(8'h00, 1'b1, err_code);
      wr_idx = 0;
      esc_ph = ESC_NONE;
      hi_nib = 4'h0;
      in_query = 1'b0;
      err_code = upd_pkg::ST_OK;
    end
  endtask

  // Output checking and prediction, both on sampled values
  name_word_t  got_w;
  name_word_t  exp_w;
  int unsigned mark_sz;
  int          case_idx;
  int          ci;

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (name_valid) begin
        got_w.nb = name_byte;
        got_w.lst = last;
        got_w.st = status;
        if (name_exp_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected output word: byte %h last %b status %0d",
                     name_byte, last, status);
        end else begin
          exp_w = name_exp_q.pop_front();
          if (got_w !== exp_w) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display({"output mismatch: expected byte %h last %b status %0d,",
                        " got byte %h last %b status %0d"},
                       exp_w.nb, exp_w.lst, exp_w.st, name_byte, last, status);
          end
        end
      end
      if (start && !busy) begin
        mark_sz = name_exp_q.size();
        decode_word(url_byte, end_of_url);
        if ((end_of_url || url_byte == 8'h00) && case_tag_q.size() != 0) begin
          case_idx = case_tag_q.pop_front();
          // hand-written expectation replaces the predicted one
          if (dir_rows[case_idx].typed) begin
            while (name_exp_q.size() > mark_sz) void'(name_exp_q.pop_back());
            for (ci = 0; ci < dir_rows[case_idx].name.len(); ci++)
              expect_word(dir_rows[case_idx].name[ci], 1'b0, upd_pkg::ST_OK);
            expect_word(8'h00, 1'b1, dir_rows[case_idx].st);
          end
        end
      end
      if (name_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("url_path_decoder_core_test failed");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] bad_hexit();
    logic [7:0] v;
    if ($urandom_range(0, 3) == 0) return upd_pkg::CH_QUERY;
    v = 8'($urandom_range(1, 255));
    while (hexit_of(v) <= 15) v = 8'($urandom_range(1, 255));
    return v;
  endfunction

  task automatic add_escape(input logic [7:0] v);
    url_q.push_back(upd_pkg::CH_PCT);
    url_q.push_back(hex_char(v[7:4]));
    url_q.push_back(hex_char(v[3:0]));
  endtask

  task automatic add_piece();
    logic [7:0] v;
    case ($urandom_range(0, 9))
      0, 1: repeat ($urandom_range(1, 3)) url_q.push_back(upd_pkg::CH_SLASH);
      2: url_q.push_back(upd_pkg::CH_DOT);
      3: begin
        url_q.push_back(upd_pkg::CH_DOT);
        url_q.push_back(upd_pkg::CH_DOT);
      end
      4, 5, 6: repeat ($urandom_range(1, 4)) url_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
      7: begin
        case ($urandom_range(0, 7))
          0: v = upd_pkg::CH_SLASH;
          1: v = upd_pkg::CH_DOT;
          2: v = 8'h00;
          3: v = upd_pkg::CH_QUERY;
          4: v = upd_pkg::CH_PCT;
          default: v = 8'($urandom_range(0, 255));
        endcase
        add_escape(v);
      end
      8: url_q.push_back(upd_pkg::CH_PLUS);
      default: begin
        v = 8'($urandom_range(1, 255));
        if (v == upd_pkg::CH_QUERY || v == upd_pkg::CH_PCT) v = 8'h78;
        url_q.push_back(v);
      end
    endcase
  endtask

  task automatic make_url();
    int unsigned kind;
    kind = $urandom_range(0, 99);
    url_q.delete();
    if (kind < 70) begin
      // mostly well-formed paths, now and then long enough to overflow
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8))
        add_piece();
      if ($urandom_range(0, 4) == 0) begin
        url_q.push_back(upd_pkg::CH_QUERY);
        repeat ($urandom_range(0, 5)) url_q.push_back(8'($urandom_range(1, 255)));
      end
    end else if (kind < 90) begin
      repeat ($urandom_range(0, 3)) add_piece();
      url_q.push_back(upd_pkg::CH_PCT);
      case ($urandom_range(0, 3))
        0: url_q.push_back(bad_hexit());
        1: begin
          url_q.push_back(hex_char(4'($urandom_range(0, 15))));
          url_q.push_back(bad_hexit());
        end
        2: ;
        default: url_q.push_back(hex_char(4'($urandom_range(0, 15))));
      endcase
      repeat ($urandom_range(0, 3)) url_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(1, 12)) url_q.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  task automatic send_word(input logic [7:0] b, input logic e, input int unsigned gap);
    start <= 1'b1;
    url_byte <= b;
    end_of_url <= e;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (gap != 0) begin
      start <= 1'b0;
      url_byte <= 8'($urandom);
      end_of_url <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (name_exp_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned r;
    int unsigned i;
    int unsigned style;
    bit burst;
    dir_rows = '{
      '{"",            1'b1, 1'b1, "",    upd_pkg::ST_OK},
      '{"abc",         1'b0, 1'b1, "abc", upd_pkg::ST_OK},
      '{"%4",          1'b0, 1'b1, "",    upd_pkg::ST_BAD_ESC},  // zero byte inside an escape
      '{"%?",          1'b1, 1'b1, "",    upd_pkg::ST_BAD_ESC},  // '?' is only a bad hexit
      '{"%",           1'b1, 1'b1, "",    upd_pkg::ST_BAD_ESC},
      '{"+%Af%00",     1'b0, 1'b0, "",    upd_pkg::ST_OK},
      '{"//b/./..?%z", 1'b1, 1'b0, "",    upd_pkg::ST_OK},
      '{"a..%2F",      1'b0, 1'b0, "",    upd_pkg::ST_OK},
      '{"\001\377",    1'b1, 1'b0, "",    upd_pkg::ST_OK}
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < DIR_ROWS; r++) begin
      case_tag_q.push_back(r);
      for (i = 0; i < dir_rows[r].url.len(); i++) send_word(dir_rows[r].url[i], 1'b0, pick_gap());
      send_word(dir_rows[r].flag_end ? 8'hFF : 8'h00, dir_rows[r].flag_end, pick_gap());
    end
    wait_quiet();

    while (items_sent < RANDOM_ITEMS) begin
      make_url();
      burst = ($urandom_range(0, 3) == 0);
      for (i = 0; i < url_q.size(); i++) send_word(url_q[i], 1'b0, burst ? 0 : pick_gap());
      style = $urandom_range(0, 2);
      case (style)
        0: send_word(8'h00, 1'b0, burst ? 0 : pick_gap());
        1: send_word(8'($urandom_range(0, 255)), 1'b1, burst ? 0 : pick_gap());
        default: send_word(8'h00, 1'b1, burst ? 0 : pick_gap());
      endcase
      if ($urandom_range(0, 19) == 0) wait_quiet();
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && name_exp_q.size() == 0) begin
      $display("url_path_decoder_core_test passed");
    end else begin
      $display("url_path_decoder_core_test failed");
    end
    $finish;
  end

endmodule
